// ===== hdl/hammer_aitoff_inverse_projection_defines.svh =====
// assertion macros for the inverse hammer-aitoff projection block
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef HAMMER_AITOFF_INVERSE_PROJECTION_DEFINES_SVH
`define HAMMER_AITOFF_INVERSE_PROJECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HAI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hai check failed");
`define HAI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hai check failed");
`else
`define HAI_ASSERT_IMP(lbl, ante, cons)
`define HAI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/hai_pkg.sv =====
// shared types and constants of the inverse hammer-aitoff projection
// no dependencies
package hai_pkg;

  // datapath widths of the normaliser and cordic row
  localparam int NormW   = 64;
  localparam int CordW   = 60;
  localparam int AngW    = 33;
  localparam int Steps   = 32;

  // per-cell control handed along the row
  typedef struct packed {
    logic en;
    logic vld;
  } hai_ctl_t;

  // atan(2^-i), 2^32 is a full turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hai_sqrt_cell.sv =====
// one digit cell of the pipelined integer square root
// depends on hai_pkg
module hai_sqrt_cell import hai_pkg::*; #(
  parameter int RB = 16,
  parameter int WW = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hai_ctl_t      ctl_i,
  input  logic [RB+1:0] rem_i,
  input  logic [RB-1:0] root_i,
  input  logic [WW-1:0] w_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [RB+1:0] rem_o,
  output logic [RB-1:0] root_o,
  output logic [WW-1:0] w_o,
  output logic [SW-1:0] side_o
);

  logic [RB+3:0] cand, trial;
  logic [RB+1:0] rem_d, rem_q;
  logic [RB-1:0] root_d, root_q;
  logic [WW-1:0] w_q;
  logic [SW-1:0] side_q;
  logic          vld_q;

  // bring down two bits and try the next root digit
  always_comb begin
    cand  = {rem_i, w_i[WW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    if (cand >= trial) begin
      rem_d  = (RB+2)'(cand - trial);
      root_d = {root_i[RB-2:0], 1'b1};
    end else begin
      rem_d  = (RB+2)'(cand);
      root_d = {root_i[RB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      w_q    <= w_i << 2;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign w_o    = w_q;
  assign side_o = side_q;

endmodule

// ===== hdl/hai_norm_cell.sv =====
// one binary-weighted shift cell of the cordic input normaliser
// depends on hai_pkg
module hai_norm_cell import hai_pkg::*; #(
  parameter int K     = 1,
  parameter bit RIGHT = 1'b0,
  parameter int SW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hai_ctl_t         ctl_i,
  input  logic [NormW-1:0] mag_i,
  input  logic [NormW-1:0] den_i,
  input  logic [SW-1:0]    side_i,
  output logic             vld_o,
  output logic [NormW-1:0] mag_o,
  output logic [NormW-1:0] den_o,
  output logic [SW-1:0]    side_o
);

  localparam logic [NormW-1:0] HiLim = NormW'(1) << (55 + K);
  localparam logic [NormW-1:0] LoLim = NormW'(1) << (56 - K);

  logic [NormW-1:0] big, mag_d, den_d, mag_q, den_q;
  logic [SW-1:0]    side_q;
  logic             vld_q, hit;

  // shift both words when the larger one is still out of range
  always_comb begin
    big = (mag_i > den_i) ? mag_i : den_i;
    hit = RIGHT ? (big >= HiLim) : (big < LoLim);
    if (!hit) begin
      mag_d = mag_i;
      den_d = den_i;
    end else if (RIGHT) begin
      mag_d = mag_i >> K;
      den_d = den_i >> K;
    end else begin
      mag_d = mag_i << K;
      den_d = den_i << K;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mag_q  <= mag_d;
      den_q  <= den_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign mag_o  = mag_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

// ===== hdl/hai_cordic_cell.sv =====
// one vectoring step of the cordic arctangent row
// depends on hai_pkg for widths and the angle table
module hai_cordic_cell import hai_pkg::*; #(
  parameter int I  = 0,
  parameter int SW = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hai_ctl_t                ctl_i,
  input  logic signed [CordW-1:0] cx_i,
  input  logic signed [CordW-1:0] cy_i,
  input  logic signed [AngW-1:0]  ang_i,
  input  logic [SW-1:0]           side_i,
  output logic                    vld_o,
  output logic signed [CordW-1:0] cx_o,
  output logic signed [CordW-1:0] cy_o,
  output logic signed [AngW-1:0]  ang_o,
  output logic [SW-1:0]           side_o
);

  localparam logic signed [AngW-1:0] Step = AngW'(atan_val(5'(I)));

  logic signed [CordW-1:0] cx_d, cy_d, cx_q, cy_q;
  logic signed [AngW-1:0]  ang_d, ang_q;
  logic [SW-1:0]           side_q;
  logic                    vld_q;

  // rotate towards the x axis, shifts floor
  always_comb begin
    if (cy_i > 0) begin
      cx_d  = cx_i + (cy_i >>> I);
      cy_d  = cy_i - (cx_i >>> I);
      ang_d = ang_i + Step;
    end else begin
      cx_d  = cx_i - (cy_i >>> I);
      cy_d  = cy_i + (cx_i >>> I);
      ang_d = ang_i - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      ang_q  <= ang_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign ang_o  = ang_q;
  assign side_o = side_q;

endmodule

// ===== hdl/hammer_aitoff_inverse_projection.sv =====
// inverse hammer-aitoff projection, fully pipelined, one beat per cycle while the skid stage is empty
// the pipeline holds the square root row (one cell per root bit), nine normaliser
// cells and 32 cordic cells
// a two-entry output register and skid stage part input and output sides
// rst_ni clears all valid bits asynchronously, payload registers are not reset
// depends on hai_pkg, hai_sqrt_cell, hai_norm_cell, hai_cordic_cell
`include "hammer_aitoff_inverse_projection_defines.svh"
module hammer_aitoff_inverse_projection import hai_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // coord_x, coord_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // mu_out, phi_out
  output logic [((COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // outside
  output logic m_axis_tuser_o
);

  localparam int CB   = COORD_BITS;
  localparam int F    = CB - 1;
  localparam int WW   = 2 * CB;
  localparam int PW   = 2 * CB + 1;
  localparam int OW   = ((CB + ANGLE_BITS + 7) / 8) * 8;
  localparam int QSW  = 4 * CB + 1;
  localparam int NSW  = CB + 3;
  localparam int NRM  = 9;
  localparam logic [WW-1:0] OneS  = WW'(1) << (2 * F);
  localparam logic [WW-1:0] TwoS  = WW'(1) << (2 * F + 1);
  localparam logic [PW-1:0] Half  = PW'(1) << (F - 1);
  localparam logic [PW-1:0] OneF  = PW'(1) << F;
  localparam logic [32:0]   Rnd   = 33'(64'h8000_0000 >> ANGLE_BITS);

  logic          out_vld_q, skid_vld_q, out_flag_q, skid_flag_q, take;
  logic [OW-1:0] out_dat_q, skid_dat_q;

  logic en;
  assign en = !skid_vld_q;
  assign s_axis_tready_o = en;

  // squares of the coordinates
  logic                 v1_q;
  logic signed [CB-1:0] x1_q, y1_q;
  logic signed [WW-1:0] xx1_q, yy1_q;
  logic signed [CB-1:0] x_in, y_in;
  assign x_in = s_axis_tdata_i[CB-1:0];
  assign y_in = s_axis_tdata_i[2*CB-1:CB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= x_in;
      y1_q  <= y_in;
      xx1_q <= x_in * x_in;
      yy1_q <= y_in * y_in;
    end
  end

  // radius test, sqrt operand and cordic denominator
  logic            v2_q, out2_q;
  logic [CB-1:0]   x2_q, y2_q;
  logic [WW-1:0]   w2_q, den2_q, s1;
  assign s1 = WW'(xx1_q) + WW'(yy1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      out2_q <= (s1 >= OneS);
      w2_q   <= TwoS - s1;
      den2_q <= OneS - s1;
    end
  end

  // square root row, one root bit per cell
  logic          sq_vld  [CB+1];
  logic [CB+1:0] sq_rem  [CB+1];
  logic [CB-1:0] sq_root [CB+1];
  logic [WW-1:0] sq_w    [CB+1];
  logic [QSW-1:0] sq_side [CB+1];

  assign sq_vld[0]  = v2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_w[0]    = w2_q;
  assign sq_side[0] = {out2_q, x2_q, y2_q, den2_q};

  for (genvar k = 0; k < CB; k++) begin : g_sqrt
    hai_sqrt_cell #(.RB(CB), .WW(WW), .SW(QSW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, vld: sq_vld[k]}),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .w_i    (sq_w[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .w_o    (sq_w[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // products with the root
  logic                 v3_q, out3_q;
  logic signed [PW-1:0] py3_q, px3_q;
  logic [WW-1:0]        den3_q;
  logic                 sq_out;
  logic signed [CB-1:0] sq_x, sq_y;
  logic [WW-1:0]        sq_den;
  assign {sq_out, sq_x, sq_y, sq_den} = sq_side[CB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sq_vld[CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out3_q <= sq_out;
      den3_q <= sq_den;
      py3_q  <= sq_y * signed'({1'b0, sq_root[CB]});
      px3_q  <= sq_x * signed'({1'b0, sq_root[CB]});
    end
  end

  // mu rounding and saturation, magnitude and sign of the numerator
  logic             v4_q;
  logic [NSW-1:0]   side4_q;
  logic [NormW-1:0] mag4_q, den4_q;
  logic             mneg, nneg;
  logic [PW-1:0]    mmag, nmag, q, qsat;
  logic [CB-1:0]    mu_d;

  always_comb begin
    mneg = py3_q[PW-1];
    mmag = mneg ? PW'(-py3_q) : PW'(py3_q);
    q    = (mmag + Half) >> F;
    if (mneg) begin
      qsat = (q > OneF) ? OneF : q;
      mu_d = CB'(~qsat + PW'(1));
    end else begin
      qsat = (q > OneF - PW'(1)) ? OneF - PW'(1) : q;
      mu_d = CB'(qsat);
    end
    nneg = px3_q[PW-1];
    nmag = nneg ? PW'(-px3_q) : PW'(px3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q  <= NormW'(nmag);
      den4_q  <= NormW'(den3_q);
      side4_q <= {out3_q, mu_d, nneg, (nmag == '0)};
    end
  end

  // normaliser row: right shifts by 4, 2, 1 then left by 32 down to 1
  logic             nm_vld  [NRM+1];
  logic [NormW-1:0] nm_mag  [NRM+1];
  logic [NormW-1:0] nm_den  [NRM+1];
  logic [NSW-1:0]   nm_side [NRM+1];

  assign nm_vld[0]  = v4_q;
  assign nm_mag[0]  = mag4_q;
  assign nm_den[0]  = den4_q;
  assign nm_side[0] = side4_q;

  for (genvar k = 0; k < NRM; k++) begin : g_norm
    localparam bit RightK = (k < 3);
    localparam int ShK    = (k < 3) ? (4 >> k) : (32 >> (k - 3));
    hai_norm_cell #(.K(ShK), .RIGHT(RightK), .SW(NSW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, vld: nm_vld[k]}),
      .mag_i  (nm_mag[k]),
      .den_i  (nm_den[k]),
      .side_i (nm_side[k]),
      .vld_o  (nm_vld[k+1]),
      .mag_o  (nm_mag[k+1]),
      .den_o  (nm_den[k+1]),
      .side_o (nm_side[k+1])
    );
  end

  // cordic row
  logic                    cd_vld  [Steps+1];
  logic signed [CordW-1:0] cd_x    [Steps+1];
  logic signed [CordW-1:0] cd_y    [Steps+1];
  logic signed [AngW-1:0]  cd_ang  [Steps+1];
  logic [NSW-1:0]          cd_side [Steps+1];

  assign cd_vld[0]  = nm_vld[NRM];
  assign cd_x[0]    = CordW'(nm_den[NRM]);
  assign cd_y[0]    = CordW'(nm_mag[NRM]);
  assign cd_ang[0]  = '0;
  assign cd_side[0] = nm_side[NRM];

  for (genvar k = 0; k < Steps; k++) begin : g_cordic
    hai_cordic_cell #(.I(k), .SW(NSW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, vld: cd_vld[k]}),
      .cx_i   (cd_x[k]),
      .cy_i   (cd_y[k]),
      .ang_i  (cd_ang[k]),
      .side_i (cd_side[k]),
      .vld_o  (cd_vld[k+1]),
      .cx_o   (cd_x[k+1]),
      .cy_o   (cd_y[k+1]),
      .ang_o  (cd_ang[k+1]),
      .side_o (cd_side[k+1])
    );
  end

  // final angle, sign, offset by half a turn and rounding
  logic                  fin_out, fin_neg, fin_zero;
  logic [CB-1:0]         fin_mu;
  logic signed [AngW-1:0] ang_s;
  logic [31:0]           p32;
  logic [32:0]           pr;
  logic [OW-1:0]         fin_dat;

  always_comb begin
    {fin_out, fin_mu, fin_neg, fin_zero} = cd_side[Steps];
    if (fin_zero) begin
      ang_s = '0;
    end else if (fin_neg) begin
      ang_s = -cd_ang[Steps];
    end else begin
      ang_s = cd_ang[Steps];
    end
    p32 = {ang_s[30:0], 1'b0} + 32'h8000_0000;
    pr  = {1'b0, p32} + Rnd;
    if (fin_out) begin
      fin_dat = '0;
    end else begin
      fin_dat = OW'({pr[31 -: ANGLE_BITS], fin_mu});
    end
  end

  // output register and skid stage
  assign take = out_vld_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (cd_vld[Steps]) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_dat_q  <= skid_dat_q;
        out_flag_q <= skid_flag_q;
      end
    end else if (cd_vld[Steps]) begin
      if (!out_vld_q || take) begin
        out_dat_q  <= fin_dat;
        out_flag_q <= fin_out;
      end else begin
        skid_dat_q  <= fin_dat;
        skid_flag_q <= fin_out;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tuser_o  = out_flag_q;

  // checks
  `HAI_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
  `HAI_ASSERT_NEXT(a_skid_needs_full_out, !out_vld_q, !skid_vld_q)
  `HAI_ASSERT_IMP(a_outside_zero, out_vld_q && out_flag_q, out_dat_q == '0)

endmodule

// ===== sim/hai_checker.sv =====
// checker for the inverse hammer-aitoff projection: watches both streams,
// predicts each result from the accepted coordinates and compares in order
// depends on nothing but the stream ports of the block
module hai_checker #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        outside;
    logic [15:0] mu;
    logic [15:0] phi;
  } sphere_pt_t;

  sphere_pt_t expected_pts[$];
  int         fails = 0;
  int         pend = 0;

  // atan(2^-i), 2^32 is a full turn
  localparam longint ArcTab[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  function automatic longint shr_floor(longint v, int i);
    return v >>> i;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring arctangent, full turn is 2^32
  function automatic longint arc_angle(longint unsigned mag, bit neg, longint unsigned den);
    longint unsigned big;
    longint cx, cy, nx, ny, ang;
    ang = 0;
    if (mag == 0) return 0;
    big = (mag > den) ? mag : den;
    while (big < (64'd1 << 55)) begin
      big <<= 1; mag <<= 1; den <<= 1;
    end
    while (big >= (64'd1 << 56)) begin
      big >>= 1; mag >>= 1; den >>= 1;
    end
    cx = longint'(den);
    cy = longint'(mag);
    for (int i = 0; i < 32; i++) begin
      if (cy > 0) begin
        nx = cx + shr_floor(cy, i);
        ny = cy - shr_floor(cx, i);
        ang += ArcTab[i];
      end else begin
        nx = cx - shr_floor(cy, i);
        ny = cy + shr_floor(cx, i);
        ang -= ArcTab[i];
      end
      cx = nx;
      cy = ny;
    end
    return neg ? -ang : ang;
  endfunction

  function automatic sphere_pt_t project_back(logic [15:0] xr, logic [15:0] yr);
    sphere_pt_t pt;
    longint x, y, r, prod, num, mu;
    longint unsigned one2, s, mag, q, p;
    bit neg;
    x    = longint'(signed'(xr));
    y    = longint'(signed'(yr));
    one2 = 64'd1 << 30;
    s    = x * x + y * y;
    pt   = '0;
    if (s >= one2) begin
      pt.outside = 1'b1;
      return pt;
    end
    r    = int_root((one2 << 1) - s);
    prod = y * r;
    neg  = prod < 0;
    mag  = neg ? -prod : prod;
    q    = (mag + (64'd1 << 14)) >> 15;
    if (neg) begin
      if (q > (64'd1 << 15)) q = 64'd1 << 15;
      mu = -longint'(q);
    end else begin
      if (q > 32767) q = 32767;
      mu = longint'(q);
    end
    num = x * r;
    neg = num < 0;
    mag = neg ? -num : num;
    p   = 2 * arc_angle(mag, neg, one2 - s) + (64'd1 << 31);
    p   = (p + (64'd1 << 15)) >> 16;
    pt.mu  = mu[15:0];
    pt.phi = p[15:0];
    return pt;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  assign fail_count_o = fails;
  assign pending_o    = pend;

  // predict on input beats, compare on output beats
  always @(posedge clk_i) begin
    sphere_pt_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        expected_pts.push_back(project_back(s_tdata_i[15:0], s_tdata_i[31:16]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_pts.pop_front();
          if (m_tuser_i !== want.outside)
            report_mismatch("outside", m_tuser_i, want.outside);
          if (m_tdata_i[15:0] !== want.mu)
            report_mismatch("mu", m_tdata_i[15:0], want.mu);
          if (m_tdata_i[31:16] !== want.phi)
            report_mismatch("phi", m_tdata_i[31:16], want.phi);
        end
      end
      pend = expected_pts.size();
    end
  end

endmodule

// ===== sim/tb_hammer_aitoff_inverse_projection.sv =====
// testbench top for the inverse hammer-aitoff projection: drives bursty
// coordinate beats, stalls the output and gives the verdict
// depends on hammer_aitoff_inverse_projection and hai_checker
module tb_hammer_aitoff_inverse_projection;

  localparam int WatchLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          stall_on = 1'b1;

  always #10 clk_i = ~clk_i;

  hammer_aitoff_inverse_projection uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  hai_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls on its own pattern: random, with a stretch of no stalls in between
  always @(negedge clk_i) begin
    if (!stall_on) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 9) < 6);
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  logic [31:0] coord_queue[$];
  int          burst_left = 0;

  // point with random content, mostly inside the ellipse
  function automatic logic [31:0] pick_point();
    int sel;
    logic [15:0] x, y;
    sel = $urandom_range(0, 9);
    x = 16'($urandom);
    y = 16'($urandom);
    if (sel < 6) begin
      x = 16'(signed'(16'(int'($urandom_range(0, 46340)) - 23170)));
      y = 16'(signed'(16'(int'($urandom_range(0, 46340)) - 23170)));
    end else if (sel == 6) begin
      x = 16'(int'($urandom_range(0, 6)) - 3);
    end else if (sel == 7) begin
      y = 16'(int'($urandom_range(0, 6)) - 3);
    end
    return {y, x};
  endfunction

  task automatic send_point(logic [31:0] d);
    while (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  initial begin
    // directed: extremes, axes, near the rim, both outside and inside
    coord_queue = '{
      {16'h0000, 16'h0000}, {16'h8000, 16'h8000}, {16'h7fff, 16'h7fff},
      {16'h0000, 16'h7fff}, {16'h0000, 16'h8000}, {16'h7fff, 16'h0000},
      {16'h8000, 16'h0000}, {16'h0000, 16'h0001}, {16'h0000, 16'hffff},
      {16'h0001, 16'h0000}, {16'hffff, 16'h0000}, {16'h7ffe, 16'h0001},
      {16'h8001, 16'hffff}, {16'h5a82, 16'h5a81}, {16'ha57e, 16'h5a81},
      {16'h5a81, 16'ha57f}, {16'h0000, 16'h7ffe}, {16'hffff, 16'h8001},
      {16'h4000, 16'h4000}, {16'hc000, 16'hc000}, {16'h2000, 16'h8001},
      {16'h5555, 16'haaaa}, {16'haaaa, 16'h5555}};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (coord_queue[i]) send_point(coord_queue[i]);
    for (int n = 0; n < 1450; n++) begin
      if (n == 700) stall_on = 1'b0;
      if (n == 900) stall_on = 1'b1;
      send_point(pick_point());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hai_pkg.sv
hdl/hai_sqrt_cell.sv
hdl/hai_norm_cell.sv
hdl/hai_cordic_cell.sv
hdl/hammer_aitoff_inverse_projection.sv
sim/hai_checker.sv
sim/tb_hammer_aitoff_inverse_projection.sv
